// File: rtl/multi_channel_led_blink_timer_unit_assert.svh
`ifndef MULTI_CHANNEL_LED_BLINK_TIMER_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_LED_BLINK_TIMER_UNIT_ASSERT_SVH

// same-cycle implication
`define MCLBT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MCLBT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mclbt_pkg.sv
package mclbt_pkg;

    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;
    localparam int CHANNELS_DEF = 6;
    localparam int LED_W        = 6;

    localparam logic [DATA_W-1:0] RESET_BLINK_MS = 32'd500;

    // register index (paddr[ADDR_W-1:2])
    localparam logic [ADDR_W-3:0] REG_DEFAULT_BLINK = 1'b0;

    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_BLINK = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    typedef struct packed {
        logic [31:0] period;
        logic [31:0] last;
        logic [31:0] deadline;
    } entry_t;

endpackage

// File: rtl/mclbt_mem.sv
module mclbt_mem #(
    parameter int DEPTH = mclbt_pkg::CHANNELS_DEF,
    parameter int AW    = 3
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  mclbt_pkg::entry_t   wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output mclbt_pkg::entry_t   rdata
);

    mclbt_pkg::entry_t mem [DEPTH];
    mclbt_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mclbt_cfg.sv
module mclbt_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mclbt_pkg::ADDR_W-1:0]      paddr,
    input  logic [mclbt_pkg::DATA_W-1:0]      pwdata,
    output logic [mclbt_pkg::DATA_W-1:0]      prdata,
    output logic                              pready,
    output logic [mclbt_pkg::DATA_W-1:0]      default_blink_ms
);

    logic [mclbt_pkg::DATA_W-1:0] default_blink_reg;
    logic [mclbt_pkg::DATA_W-1:0] default_blink_next;
    logic                         hit;

    assign hit    = (paddr[mclbt_pkg::ADDR_W-1:2] == mclbt_pkg::REG_DEFAULT_BLINK);
    assign pready = 1'b1;

    always_comb
    begin
        default_blink_next = default_blink_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            default_blink_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_blink_reg <= mclbt_pkg::RESET_BLINK_MS;
        end
        else
        begin
            default_blink_reg <= default_blink_next;
        end
    end

    assign prdata           = hit ? default_blink_reg : '0;
    assign default_blink_ms = default_blink_reg;

endmodule

// File: rtl/multi_channel_led_blink_timer_unit.sv
// LED blink timer, CHANNELS channels, millisecond time base.
// Input channel (item_valid / item_stall): one word per action: set a steady
// level, start blinking (optional period and auto-off delay) or a 1 ms tick.
// Output channel (result_valid / result_stall): one word per input word with
// the LED levels and the millisecond counter after that action.
// Config: APB register 0 holds the default blink period (reset 500 ms).
// Set, blink and unused actions go from accept to ST_DONE and then into the
// output register. A tick first passes ST_SCAN, where the channel entries
// sit in a one-port-read memory and are read, updated and written back one
// per cycle through a two-stage read/modify pipe.
// One word is in work at a time; item_stall is high until its result is
// loaded into the output register. A result waiting under result_stall does
// not block the next word, only the loading of its result.
// Reset clears time, levels and blink flags. Channel entries need no clear:
// they are read for every channel but only used for a blinking one, which is always written first.
module multi_channel_led_blink_timer_unit #(
    parameter int CHANNELS = mclbt_pkg::CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [1:0]                         action,
    input  logic [2:0]                         channel,
    input  logic                               level,
    input  logic [31:0]                        period_ms,
    input  logic [31:0]                        auto_off_ms,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [mclbt_pkg::LED_W-1:0]        led_levels,
    output logic [31:0]                        time_ms,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mclbt_pkg::ADDR_W-1:0]       paddr,
    input  logic [mclbt_pkg::DATA_W-1:0]       pwdata,
    output logic [mclbt_pkg::DATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(CHANNELS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [31:0]                  now_reg, now_next;
    logic [CHANNELS-1:0]          lamp_reg, lamp_next;
    logic [CHANNELS-1:0]          blinking_reg, blinking_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         proc_valid_reg, proc_valid_next;
    logic [AW-1:0]                proc_idx_reg;
    logic                         result_valid_reg, result_valid_next;
    logic [mclbt_pkg::LED_W-1:0]  led_levels_reg;
    logic [31:0]                  time_ms_reg;

    logic [31:0]                  default_blink_ms;
    logic                         accept;
    logic                         load_out;
    logic [CHANNELS-1:0]          sel_in;
    logic [CHANNELS-1:0]          proc_sel;
    logic [mclbt_pkg::LED_W-1:0]  led_bits;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    mclbt_pkg::entry_t            mem_wdata;
    logic                         mem_re;
    mclbt_pkg::entry_t            mem_rdata;

    mclbt_pkg::entry_t            blink_entry;
    logic [31:0]                  diff_d;
    logic [31:0]                  diff_t;
    logic                         cur_blink;
    logic                         expire;
    logic                         toggle;

    mclbt_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .default_blink_ms (default_blink_ms)
    );

    mclbt_mem #(
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_sel
        assign sel_in[i]   = (32'(channel) == i);
        assign proc_sel[i] = (proc_idx_reg == AW'(i));
    end

    for (genvar j = 0; j < mclbt_pkg::LED_W; j++)
    begin : g_led
        if (j < CHANNELS)
        begin : g_on
            assign led_bits[j] = lamp_reg[j];
        end
        else
        begin : g_off
            assign led_bits[j] = 1'b0;
        end
    end

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign load_out   = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);

    // blink start entry
    always_comb
    begin
        blink_entry.period   = (period_ms == 32'd0) ? default_blink_ms : period_ms;
        blink_entry.last     = now_reg;
        blink_entry.deadline = (auto_off_ms != 32'd0) ? (now_reg + auto_off_ms) : 32'd0;
    end

    // per-channel tick update on the read data
    assign cur_blink = blinking_reg[proc_idx_reg];
    assign diff_d    = now_reg - mem_rdata.deadline;
    assign diff_t    = now_reg - mem_rdata.last;
    assign expire    = cur_blink && (mem_rdata.deadline != 32'd0) && !diff_d[31];
    assign toggle    = cur_blink && !expire && (diff_t >= mem_rdata.period);

    // reads of entry i overlap only the write-back of entry i-1: no forwarding
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(channel);
        mem_wdata = blink_entry;
        mem_re    = 1'b0;
        if (accept && (action == mclbt_pkg::ACT_BLINK) && (|sel_in))
        begin
            mem_we = 1'b1;
        end
        if ((state_reg == ST_SCAN) && proc_valid_reg && toggle)
        begin
            mem_we         = 1'b1;
            mem_waddr      = proc_idx_reg;
            mem_wdata      = mem_rdata;
            mem_wdata.last = now_reg;
        end
        if ((state_reg == ST_SCAN) && (cnt_reg != CW'(CHANNELS)))
        begin
            mem_re = 1'b1;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        now_next          = now_reg;
        lamp_next         = lamp_reg;
        blinking_next     = blinking_reg;
        cnt_next          = cnt_reg;
        proc_valid_next   = 1'b0;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DONE;
                    unique case (action)
                        mclbt_pkg::ACT_SET:
                        begin
                            lamp_next     = (lamp_reg & ~sel_in) | (sel_in & {CHANNELS{level}});
                            blinking_next = blinking_reg & ~sel_in;
                        end
                        mclbt_pkg::ACT_BLINK:
                        begin
                            blinking_next = blinking_reg | sel_in;
                        end
                        mclbt_pkg::ACT_TICK:
                        begin
                            now_next   = now_reg + 32'd1;
                            cnt_next   = '0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg != CW'(CHANNELS))
                begin
                    proc_valid_next = 1'b1;
                    cnt_next        = cnt_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
                if (proc_valid_reg)
                begin
                    if (expire)
                    begin
                        blinking_next = blinking_reg & ~proc_sel;
                        lamp_next     = lamp_reg & ~proc_sel;
                    end
                    else if (toggle)
                    begin
                        lamp_next = lamp_reg ^ proc_sel;
                    end
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            now_reg          <= '0;
            lamp_reg         <= '0;
            blinking_reg     <= '0;
            cnt_reg          <= '0;
            proc_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            now_reg          <= now_next;
            lamp_reg         <= lamp_next;
            blinking_reg     <= blinking_next;
            cnt_reg          <= cnt_next;
            proc_valid_reg   <= proc_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg <= cnt_reg[AW-1:0];
        if (load_out)
        begin
            led_levels_reg <= led_bits;
            time_ms_reg    <= now_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign led_levels   = led_levels_reg;
    assign time_ms      = time_ms_reg;

endmodule

// File: rtl/mclbt_checker.sv
`include "multi_channel_led_blink_timer_unit_assert.svh"

module mclbt_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               item_valid,
    input logic                               item_stall,
    input logic                               result_valid,
    input logic                               result_stall,
    input logic [mclbt_pkg::LED_W-1:0]        led_levels,
    input logic [31:0]                        time_ms,
    input logic                               psel,
    input logic                               penable,
    input logic                               pready
);

    // stalled result word holds
    `MCLBT_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(led_levels) && $stable(time_ms), "result word changed under stall")

    // one word in work at a time
    `MCLBT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, item_valid && !item_stall, item_stall, "input taken while busy")

    // a new result only comes out of a word in work
    `MCLBT_ASSERT_IMP(a_result_from_work, clk, rst_n, $rose(result_valid), $past(item_stall), "result without a word in work")

    `MCLBT_ASSERT_IMP(a_apb_ready, clk, rst_n, psel && penable, pready, "APB access not ready")

endmodule

bind multi_channel_led_blink_timer_unit mclbt_checker u_mclbt_checker (.*);

// File: bench/tb_multi_channel_led_blink_timer_unit.sv
`timescale 1ns / 100ps

module tb_multi_channel_led_blink_timer_unit;

    localparam int NUM_LEDS = 6;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam logic [mclbt_pkg::ADDR_W-1:0] ADDR_DEFAULT = {mclbt_pkg::REG_DEFAULT_BLINK, 2'b00};
    localparam logic [mclbt_pkg::ADDR_W-1:0] ADDR_UNUSED = 3'd4;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 250;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  channel;
        logic        level;
        logic [31:0] period;
        logic [31:0] auto_off;
    } led_cmd_t;

    typedef struct packed {
        logic [mclbt_pkg::LED_W-1:0] leds;
        logic [31:0]                 now;
    } led_view_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          item_valid = 1'b0;
    logic                          item_stall;
    logic [1:0]                    action = '0;
    logic [2:0]                    channel = '0;
    logic                          level = 1'b0;
    logic [31:0]                   period_ms = '0;
    logic [31:0]                   auto_off_ms = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic [mclbt_pkg::LED_W-1:0]   led_levels;
    logic [31:0]                   time_ms;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [mclbt_pkg::ADDR_W-1:0]  paddr = '0;
    logic [mclbt_pkg::DATA_W-1:0]  pwdata = '0;
    logic [mclbt_pkg::DATA_W-1:0]  prdata;
    logic                          pready;

    multi_channel_led_blink_timer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .channel      (channel),
        .level        (level),
        .period_ms    (period_ms),
        .auto_off_ms  (auto_off_ms),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .led_levels   (led_levels),
        .time_ms      (time_ms),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 clk = ~clk;

    // predictor state
    logic [31:0]         dflt_period;
    logic [31:0]         ms_count;
    logic [NUM_LEDS-1:0] lamp_on;
    logic [NUM_LEDS-1:0] flashing;
    logic [31:0]         flash_period [NUM_LEDS];
    logic [31:0]         toggled_at [NUM_LEDS];
    logic [31:0]         off_at [NUM_LEDS];

    led_cmd_t  pending_words [$];
    led_view_t led_forecast [$];

    int  mismatches = 0;
    int  accepted_cnt = 0;
    int  results_seen = 0;
    int  ticks_seen = 0;
    int  blinks_seen = 0;
    int  sets_seen = 0;
    int  settings_used = 0;
    int  ticks_queued = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  in_fire = 1'b0;
    bit  quiet_tail = 1'b0;

    led_cmd_t  drv_word;
    led_cmd_t  seen_word;
    led_view_t seen_view;
    led_view_t want_view;

    function automatic bit idle_on();
        return !quiet_tail && ((accepted_cnt / 80) % 4 != 3);
    endfunction

    function automatic void report(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected %h got %h", $realtime, what, want, got);
    endfunction

    task automatic apply_led_word(input led_cmd_t c, output led_view_t r);
        logic [31:0] diff;
        case (c.action)
            mclbt_pkg::ACT_SET:
                if (c.channel < NUM_LEDS)
                begin
                    flashing[c.channel] = 1'b0;
                    lamp_on[c.channel] = c.level;
                    off_at[c.channel] = '0;
                end
            mclbt_pkg::ACT_BLINK:
                if (c.channel < NUM_LEDS)
                begin
                    flashing[c.channel] = 1'b1;
                    flash_period[c.channel] = (c.period == 0) ? dflt_period : c.period;
                    toggled_at[c.channel] = ms_count;
                    off_at[c.channel] = (c.auto_off != 0) ? ms_count + c.auto_off : 32'd0;
                end
            mclbt_pkg::ACT_TICK:
            begin
                ms_count = ms_count + 32'd1;
                for (int i = 0; i < NUM_LEDS; i++)
                begin
                    if (flashing[i])
                    begin
                        diff = ms_count - off_at[i];
                        if (off_at[i] != 0 && !diff[31])
                        begin
                            flashing[i] = 1'b0;
                            lamp_on[i] = 1'b0;
                            off_at[i] = '0;
                        end
                        else
                        begin
                            diff = ms_count - toggled_at[i];
                            if (diff >= flash_period[i])
                            begin
                                lamp_on[i] = ~lamp_on[i];
                                toggled_at[i] = ms_count;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        r.leds = lamp_on;
        r.now = ms_count;
    endtask

    // monitor and prediction
    always @(posedge clk)
    begin
        in_fire = rst_n && item_valid && !item_stall;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (led_forecast.size() == 0)
                report("result with no word pending", 32'hxxxx_xxxx, time_ms);
            else
            begin
                want_view = led_forecast.pop_front();
                if (led_levels !== want_view.leds)
                    report("led_levels", 32'(want_view.leds), 32'(led_levels));
                if (time_ms !== want_view.now)
                    report("time_ms", want_view.now, time_ms);
            end
        end
        if (in_fire)
        begin
            seen_word.action = action;
            seen_word.channel = channel;
            seen_word.level = level;
            seen_word.period = period_ms;
            seen_word.auto_off = auto_off_ms;
            apply_led_word(seen_word, seen_view);
            led_forecast.push_back(seen_view);
            accepted_cnt++;
            if (action == mclbt_pkg::ACT_TICK)
                ticks_seen++;
            else if (action == mclbt_pkg::ACT_BLINK)
                blinks_seen++;
            else if (action == mclbt_pkg::ACT_SET)
                sets_seen++;
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                item_valid <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (pending_words.size() > 0)
            begin
                drv_word = pending_words.pop_front();
                action <= drv_word.action;
                channel <= drv_word.channel;
                level <= drv_word.level;
                period_ms <= drv_word.period;
                auto_off_ms <= drv_word.auto_off;
                item_valid <= 1'b1;
                if (idle_on() && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 9);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // long receiver hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && accepted_cnt >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // output stall driver
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (idle_on() && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            result_stall <= 1'b1;
        end
        else
            result_stall <= (hold_left > 0);
    end

    task automatic push_word(logic [1:0] a, logic [2:0] ch, logic lv, logic [31:0] p,
                             logic [31:0] ao);
        led_cmd_t c;
        c.action = a;
        c.channel = ch;
        c.level = lv;
        c.period = p;
        c.auto_off = ao;
        pending_words.push_back(c);
        if (a == mclbt_pkg::ACT_TICK)
            ticks_queued++;
    endtask

    task automatic run_phase(int n);
        logic [1:0]  a;
        logic [2:0]  ch;
        logic [31:0] p;
        logic [31:0] ao;
        int          r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            a = (r < 50) ? mclbt_pkg::ACT_TICK : (r < 78) ? mclbt_pkg::ACT_BLINK
              : (r < 95) ? mclbt_pkg::ACT_SET : ACT_NONE;
            ch = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, NUM_LEDS - 1));
            r = $urandom_range(0, 99);
            if (r < 20)
                p = '0;
            else if (r < 80)
                p = $urandom_range(1, 12);
            else if (r < 90)
                p = $urandom;
            else
                p = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
            r = $urandom_range(0, 99);
            if (r < 40)
                ao = '0;
            else if (r < 80)
                ao = $urandom_range(1, 60);
            else if (r < 97)
                ao = $urandom;
            else
                ao = 32'd0 - 32'(ticks_queued);
            push_word(a, ch, 1'($urandom_range(0, 1)), p, ao);
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || led_forecast.size() != 0 || item_valid)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic apb_write(logic [mclbt_pkg::ADDR_W-1:0] addr,
                             logic [mclbt_pkg::DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_default();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_DEFAULT;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== dflt_period)
            report("default_blink_ms readback", dflt_period, prdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_default(logic [31:0] v);
        apb_write(ADDR_DEFAULT, v);
        dflt_period = v;
        settings_used++;
        check_default();
    endtask

    initial
    begin
        dflt_period = mclbt_pkg::RESET_BLINK_MS;
        ms_count = '0;
        lamp_on = '0;
        flashing = '0;
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            flash_period[i] = mclbt_pkg::RESET_BLINK_MS;
            toggled_at[i] = '0;
            off_at[i] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);
        check_default();

        // directed: extremes, ignored channels, unused action, deadline corner cases
        push_word(mclbt_pkg::ACT_TICK, 3'd0, 1'b0, 32'd0, 32'd0);
        push_word(mclbt_pkg::ACT_SET, 3'd0, 1'b1, 32'd0, 32'd0);
        push_word(mclbt_pkg::ACT_SET, 3'd5, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(mclbt_pkg::ACT_SET, 3'd6, 1'b1, 32'd0, 32'd0);
        push_word(mclbt_pkg::ACT_BLINK, 3'd7, 1'b1, 32'd1, 32'd5);
        push_word(ACT_NONE, 3'd2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(mclbt_pkg::ACT_BLINK, 3'd0, 1'b0, 32'd0, 32'd0);
        push_word(mclbt_pkg::ACT_BLINK, 3'd1, 1'b0, 32'd1, 32'd3);
        push_word(mclbt_pkg::ACT_BLINK, 3'd2, 1'b0, 32'd2, 32'hFFFF_FFFF);
        push_word(mclbt_pkg::ACT_BLINK, 3'd3, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000);
        push_word(mclbt_pkg::ACT_BLINK, 3'd4, 1'b0, 32'd3, 32'd0 - 32'(ticks_queued));
        push_word(mclbt_pkg::ACT_BLINK, 3'd5, 1'b0, 32'd1, 32'h7FFF_FFFF);
        repeat (6) push_word(mclbt_pkg::ACT_TICK, 3'd7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(mclbt_pkg::ACT_SET, 3'd1, 1'b0, 32'd0, 32'd0);
        push_word(mclbt_pkg::ACT_BLINK, 3'd7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (5) push_word(mclbt_pkg::ACT_TICK, 3'd0, 1'b0, 32'd0, 32'd0);
        run_phase(200);
        wait_idle();

        set_default(32'd1);
        run_phase(200);
        wait_idle();

        set_default(32'hFFFF_FFFF);
        run_phase(200);
        wait_idle();

        // write to an unused register index must leave the default alone
        apb_write(ADDR_UNUSED, $urandom);
        check_default();
        set_default(32'd7);
        run_phase(200);
        wait_idle();

        set_default($urandom_range(2, 40));
        run_phase(250);
        wait_idle();

        quiet_tail = 1'b1;
        set_default(mclbt_pkg::RESET_BLINK_MS);
        run_phase(200);
        wait_idle();
        repeat (20) @(posedge clk);

        if (led_forecast.size() != 0)
        begin
            $display("%0d results never arrived", led_forecast.size());
            mismatches += led_forecast.size();
        end
        $display("%0d words in (%0d ticks, %0d blinks, %0d sets), %0d results checked",
                 accepted_cnt, ticks_seen, blinks_seen, sets_seen, results_seen);
        $display("%0d default period settings, one long output hold-off, %0d mismatches",
                 settings_used, mismatches);
        if (mismatches == 0)
            $display("multi_channel_led_blink_timer_unit: match");
        else
            $display("multi_channel_led_blink_timer_unit: mismatch");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("timeout");
        $display("multi_channel_led_blink_timer_unit: mismatch");
        $finish;
    end

endmodule
